@@ design/kdlp_pkg.sv @@
// Package: item types, register indexes and reset values for the key qualifier.
`default_nettype none
package kdlp_pkg;

  localparam int unsigned TickW = 32;
  localparam int unsigned TimeW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = TimeW;

  localparam logic [CfgIdxW-1:0] REG_ACTIVE_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_REPEAT = 2'd3;

  localparam logic RstActiveHigh = 1'b0;
  localparam logic [TimeW-1:0] RstDebounce = 16'd20;
  localparam logic [TimeW-1:0] RstLongPress = 16'd1000;
  localparam logic [TimeW-1:0] RstRepeat = 16'd200;

  typedef enum logic [1:0] {
    KM_IDLE   = 2'd0,
    KM_SETTLE = 2'd1,
    KM_HELD   = 2'd2,
    KM_LONG   = 2'd3
  } key_mode_t;

  typedef struct packed {
    logic             pin_level;
    logic [TickW-1:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic      press_event;
    logic      long_press_event;
    logic [1:0] key_mode;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/key_debounce_long_press.sv @@
// Key debounce with long-press and repeat reporting, one scan item per cycle unless out_ready stalls.
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle; in_ready stays high while the output register
// is empty or being taken, so the one-stage output register sets the rate.
// Reset (rst_n low, synchronous): key state idle, mark tick zero, output empty,
// configuration back to active low, debounce 20, long press 1000, repeat 200.
`default_nettype none
module key_debounce_long_press (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire kdlp_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output kdlp_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [kdlp_pkg::CfgIdxW-1:0]  cfg_idx,
  input  wire logic [kdlp_pkg::CfgDataW-1:0] cfg_wdata
);
  import kdlp_pkg::*;

  logic             active_high_r;
  logic [TimeW-1:0] debounce_r;
  logic [TimeW-1:0] long_press_r;
  logic [TimeW-1:0] repeat_r;

  key_mode_t        mode_r, mode_nxt;
  logic [TickW-1:0] mark_r, mark_nxt;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;

  logic             in_fire;
  logic             active;
  logic [TickW-1:0] elapsed;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign active  = (in_data.pin_level == active_high_r);
  assign elapsed = in_data.now_tick - mark_r;

  always_comb begin
    mode_nxt = mode_r;
    mark_nxt = mark_r;
    out_nxt.press_event = 1'b0;
    out_nxt.long_press_event = 1'b0;
    unique case (mode_r)
      KM_IDLE: begin
        if (active) begin
          mode_nxt = KM_SETTLE;
          mark_nxt = in_data.now_tick;
        end
      end
      KM_SETTLE: begin
        if (!active) begin
          mode_nxt = KM_IDLE;
        end else if (elapsed > {{(TickW-TimeW){1'b0}}, debounce_r}) begin
          mode_nxt = KM_HELD;
          mark_nxt = in_data.now_tick;
          out_nxt.press_event = 1'b1;
        end
      end
      KM_HELD: begin
        if (!active) begin
          mode_nxt = KM_IDLE;
        end else if (elapsed >= {{(TickW-TimeW){1'b0}}, long_press_r}) begin
          mode_nxt = KM_LONG;
          mark_nxt = in_data.now_tick;
          out_nxt.long_press_event = 1'b1;
        end
      end
      KM_LONG: begin
        if (!active) begin
          mode_nxt = KM_IDLE;
        end else if (elapsed >= {{(TickW-TimeW){1'b0}}, repeat_r}) begin
          mark_nxt = in_data.now_tick;
          out_nxt.long_press_event = 1'b1;
        end
      end
      default: begin
        mode_nxt = KM_IDLE;
      end
    endcase
    out_nxt.key_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r <= RstActiveHigh;
      debounce_r    <= RstDebounce;
      long_press_r  <= RstLongPress;
      repeat_r      <= RstRepeat;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ACTIVE_HIGH: active_high_r <= cfg_wdata[0];
        REG_DEBOUNCE:    debounce_r    <= cfg_wdata;
        REG_LONG_PRESS:  long_press_r  <= cfg_wdata;
        REG_REPEAT:      repeat_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= KM_IDLE;
      mark_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r      <= mode_nxt;
        mark_r      <= mark_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  a_press_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.press_event) |-> (out_data.key_mode == KM_HELD))
    else $error("press reported outside pressed mode");

  a_long_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.long_press_event) |-> (out_data.key_mode == KM_LONG))
    else $error("long press reported outside long-press mode");

  a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.key_mode == mode_r))
    else $error("result mode differs from held key state");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output not empty after reset");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the key qualifier: scan stimulus, report predictor and result checker.
`timescale 1ns / 100ps
module tb_top;
  import kdlp_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ScansPerPhase = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  key_debounce_long_press i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // key state and settings as the block should hold them
  key_mode_t key_st = KM_IDLE;
  logic [TickW-1:0] mark_tick = '0;
  logic act_high = RstActiveHigh;
  logic [TimeW-1:0] db_ticks = RstDebounce;
  logic [TimeW-1:0] lp_ticks = RstLongPress;
  logic [TimeW-1:0] rp_ticks = RstRepeat;

  in_item_t pending_scans[$];
  out_item_t exp_reports[$];
  logic scan_busy = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_left = 0;
  int unsigned idle_cycles = 0;

  logic [TickW-1:0] gen_tick = '0;
  logic gen_held = 1'b0;
  int unsigned gen_run = 0;

  int unsigned err_cnt = 0;
  int unsigned n_scans = 0;
  int unsigned n_reports = 0;
  int unsigned n_press = 0;
  int unsigned n_long = 0;
  int unsigned n_settings = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic out_item_t scan_key(input in_item_t s);
    out_item_t r;
    logic active;
    logic [TickW-1:0] elapsed;
    active = (s.pin_level == act_high);
    elapsed = s.now_tick - mark_tick;
    r = '0;
    case (key_st)
      KM_IDLE: begin
        if (active) begin
          key_st = KM_SETTLE;
          mark_tick = s.now_tick;
        end
      end
      KM_SETTLE: begin
        if (!active) begin
          key_st = KM_IDLE;
        end else if (elapsed > db_ticks) begin
          key_st = KM_HELD;
          r.press_event = 1'b1;
          mark_tick = s.now_tick;
        end
      end
      KM_HELD: begin
        if (!active) begin
          key_st = KM_IDLE;
        end else if (elapsed >= lp_ticks) begin
          key_st = KM_LONG;
          r.long_press_event = 1'b1;
          mark_tick = s.now_tick;
        end
      end
      default: begin
        if (!active) begin
          key_st = KM_IDLE;
        end else if (elapsed >= rp_ticks) begin
          r.long_press_event = 1'b1;
          mark_tick = s.now_tick;
        end
      end
    endcase
    r.key_mode = key_st;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want_v);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want_v);
    err_cnt++;
  endtask

  // driver: present the next scan item at the falling edge
  always @(negedge clk) begin
    if (!scan_busy) begin
      if (pending_scans.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_data <= pending_scans.pop_front();
        in_valid <= 1'b1;
        scan_busy = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold_left != 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor: check each result, then predict for the item taken at this edge
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_reports++;
        if (out_data.press_event === 1'b1) n_press++;
        if (out_data.long_press_event === 1'b1) n_long++;
        if (exp_reports.size() == 0) begin
          flag_mismatch("unexpected result", out_data, 0);
        end else begin
          want = exp_reports.pop_front();
          if (out_data.press_event !== want.press_event)
            flag_mismatch("press_event", out_data.press_event, want.press_event);
          if (out_data.long_press_event !== want.long_press_event)
            flag_mismatch("long_press_event", out_data.long_press_event,
                          want.long_press_event);
          if (out_data.key_mode !== want.key_mode)
            flag_mismatch("key_mode", out_data.key_mode, want.key_mode);
        end
      end
      if (in_valid && in_ready) begin
        exp_reports.push_back(scan_key(in_data));
        scan_busy = 1'b0;
        n_scans++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == StallLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic add_scan(input logic pin, input logic [TickW-1:0] tick);
    in_item_t s;
    s.pin_level = pin;
    s.now_tick = tick;
    pending_scans.push_back(s);
  endtask

  task automatic wait_drained();
    while (pending_scans.size() != 0 || scan_busy || exp_reports.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_setting(input logic ah, input logic [TimeW-1:0] db,
                              input logic [TimeW-1:0] lp, input logic [TimeW-1:0] rp);
    put_reg(REG_ACTIVE_HIGH, {15'($urandom), ah});
    put_reg(REG_DEBOUNCE, db);
    put_reg(REG_LONG_PRESS, lp);
    put_reg(REG_REPEAT, rp);
    @(negedge clk);
    cfg_we <= 1'b0;
    act_high = ah;
    db_ticks = db;
    lp_ticks = lp;
    rp_ticks = rp;
    n_settings++;
  endtask

  // mostly held runs with steps around the thresholds, some glitches and tick jumps
  task automatic gen_scans(input int unsigned n);
    int unsigned r;
    int unsigned span;
    logic [TickW-1:0] step;
    logic pin;
    span = db_ticks;
    if (lp_ticks > span) span = lp_ticks;
    if (rp_ticks > span) span = rp_ticks;
    for (int unsigned k = 0; k < n; k++) begin
      if (gen_run == 0) begin
        gen_held = ($urandom_range(0, 9) < 7);
        gen_run = gen_held ? $urandom_range(1, 24) : $urandom_range(1, 4);
      end
      gen_run--;
      r = $urandom_range(0, 99);
      if (r < 10) step = '0;
      else if (r < 20) step = 1;
      else if (r < 30) step = db_ticks;
      else if (r < 35) step = db_ticks + 1;
      else if (r < 45) step = lp_ticks;
      else if (r < 50) step = lp_ticks - 1;
      else if (r < 60) step = rp_ticks;
      else if (r < 65) step = rp_ticks + 1;
      else if (r < 92) step = $urandom_range(0, span / 2 + 1);
      else if (r < 97) step = $urandom;
      else begin
        step = '0;
        gen_tick = '1 - $urandom_range(0, span);
      end
      gen_tick = gen_tick + step;
      pin = (gen_held && $urandom_range(0, 19) != 0) ? act_high : ~act_high;
      add_scan(pin, gen_tick);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: active low, debounce 20, long press 1000, repeat 200
    tx_idle_pct = 6;
    rx_idle_pct = 87;
    add_scan(1'b1, 32'h0000_0000);
    add_scan(1'b0, 32'hFFFF_FFF0);
    add_scan(1'b0, 32'h0000_0004);
    add_scan(1'b0, 32'h0000_0005);
    add_scan(1'b0, 32'd1004);
    add_scan(1'b0, 32'd1005);
    add_scan(1'b0, 32'd1204);
    add_scan(1'b0, 32'd1205);
    add_scan(1'b1, 32'd1300);
    add_scan(1'b0, 32'd2000);
    add_scan(1'b1, 32'd2001);
    add_scan(1'b0, 32'd3000);
    add_scan(1'b0, 32'd2999);
    add_scan(1'b1, 32'd3000);
    add_scan(1'b0, 32'hFFFF_FFFF);
    add_scan(1'b0, 32'h7FFF_FFFF);
    wait_drained();

    // zero thresholds, active high
    load_setting(1'b1, '0, '0, '0);
    add_scan(1'b0, 32'd100);
    add_scan(1'b1, 32'd100);
    add_scan(1'b1, 32'd100);
    add_scan(1'b1, 32'd101);
    add_scan(1'b1, 32'd101);
    add_scan(1'b1, 32'd101);
    add_scan(1'b0, 32'd101);
    wait_drained();

    for (int s = 0; s < 6; s++) begin
      case (s)
        0: load_setting(RstActiveHigh, RstDebounce, RstLongPress, RstRepeat);
        1: load_setting(1'b1, '0, '0, '0);
        2: load_setting(1'b0, '1, '1, '1);
        3: load_setting(1'b1, 16'd3, 16'd40, 16'd7);
        4: load_setting(1'($urandom_range(0, 1)), 16'($urandom_range(0, 300)),
                        16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
        default: load_setting(1'($urandom_range(0, 1)), 16'($urandom),
                              16'($urandom), 16'($urandom));
      endcase
      for (int m = 0; m < 3; m++) begin
        tx_idle_pct = (m == 0) ? 6 : (m == 1) ? 87 : 0;
        rx_idle_pct = (m == 0) ? 87 : (m == 1) ? 6 : 0;
        if (s == 3 && m == 2) rx_hold_left = 300;
        gen_scans(ScansPerPhase);
        wait_drained();
      end
    end

    repeat (4) @(posedge clk);
    $display("scan items %0d, results checked %0d, press reports %0d, long press reports %0d",
             n_scans, n_reports, n_press, n_long);
    $display("%0d settings loaded: both active levels, zero and full-scale thresholds, tick wrap",
             n_settings);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
